/* hdl/nba_pkg.sv */
// ----------------------------------------------------------------------------
// nba_pkg
// Shared widths, status codes and controller/datapath interface types for
// the NTILE bucket assignment unit.
// ----------------------------------------------------------------------------
package nba_pkg;

    localparam int ROW_BITS_DEF = 32;   // default width of the row position
    localparam int ROWS_W       = 32;   // partition row count
    localparam int BUCKETS_W    = 33;   // signed bucket count
    localparam int BUCKET_W     = 33;   // result bucket number
    localparam int STATUS_W     = 2;
    localparam int DIVISOR_W    = 33;   // q+1 may reach 2^32

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture an accepted word and advance the position
        logic div1_start;   // start rows / buckets
        logic qr_load;      // latch quotient and remainder of the first division
        logic mul_en;       // form r * q
        logic div2_start;   // start the bucket division
        logic res_load;     // write the output register
    } nba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fast;         // result known without division
        logic div_done;     // divider finished this cycle
    } nba_stat_t;

endpackage

/* hdl/nba_divider.sv */
// ----------------------------------------------------------------------------
// nba_divider
// Radix-2 restoring divider, one quotient bit per cycle. The quotient and
// remainder hold their values after done until the next start.
// ----------------------------------------------------------------------------
module nba_divider #(
    parameter int DW = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DW-1:0]                 dividend,
    input  logic [nba_pkg::DIVISOR_W-1:0] divisor,
    output logic                          done,
    output logic [DW-1:0]                 quotient,
    output logic [nba_pkg::DIVISOR_W-1:0] remainder
);
    import nba_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]        quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = shifted >= {1'b0, dvs_reg};
        // The partial remainder stays below the divisor, so it fits its width.
        rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_next = {quo_reg[DW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/nba_datapath.sv */
// ----------------------------------------------------------------------------
// nba_datapath
// Row position counter, input classification, bucket arithmetic around a
// shared divider, and the output register.
// ----------------------------------------------------------------------------
module nba_datapath #(
    parameter int ROW_BITS = nba_pkg::ROW_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          first_row,
    input  logic [nba_pkg::ROWS_W-1:0]    partition_rows,
    input  logic [nba_pkg::BUCKETS_W-1:0] buckets,
    input  logic                          buckets_null,
    input  nba_pkg::nba_cmd_t             cmd,
    output nba_pkg::nba_stat_t            stat,
    output logic [nba_pkg::BUCKET_W-1:0]  bucket,
    output logic [nba_pkg::STATUS_W-1:0]  status
);
    import nba_pkg::*;

    localparam int DW  = (ROW_BITS > ROWS_W) ? ROW_BITS : ROWS_W;
    localparam int EXT = (ROW_BITS + 1 > BUCKET_W) ? ROW_BITS + 1 : BUCKET_W;
    localparam int CW  = (ROW_BITS > BUCKET_W) ? ROW_BITS : BUCKET_W;

    logic [ROW_BITS-1:0]  pos_reg;
    logic [ROW_BITS-1:0]  cur_pos_reg;
    logic [ROWS_W-1:0]    rows_reg;
    logic [ROWS_W-1:0]    nb_reg;
    logic                 fast_reg;
    logic [BUCKET_W-1:0]  fast_bucket_reg;
    logic [STATUS_W-1:0]  fast_status_reg;
    logic [ROWS_W-1:0]    q_reg;
    logic [ROWS_W-1:0]    r_reg;
    logic [ROWS_W-1:0]    prod_reg;
    logic [BUCKET_W-1:0]  bucket_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic [ROW_BITS-1:0]  cur_pos;
    logic [ROW_BITS:0]    pos_inc;
    logic [EXT-1:0]       pos_inc_ext;
    logic                 in_fast;
    logic [BUCKET_W-1:0]  in_bucket;
    logic [STATUS_W-1:0]  in_status;

    logic [2*ROWS_W-1:0]  prod_full;
    logic [BUCKET_W-1:0]  boundary;
    logic                 below;
    logic [DW-1:0]        div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic [DIVISOR_W-1:0] div_rem;
    logic [DW:0]          quo_inc;

    // Classification of an incoming word, and the bucket when no division
    // is needed. Null wins over the error check.
    always_comb begin
        cur_pos     = first_row ? '0 : pos_reg;
        pos_inc     = {1'b0, cur_pos} + (ROW_BITS+1)'(1);
        pos_inc_ext = EXT'(pos_inc);
        in_fast     = 1'b1;
        in_bucket   = '0;
        in_status   = ST_OK;
        if (buckets_null) begin
            in_status = ST_NULL;
        end else if (buckets[BUCKETS_W-1] || (buckets == '0)) begin
            in_status = ST_ERR;
        end else if (buckets[ROWS_W-1:0] > partition_rows) begin
            in_bucket = pos_inc_ext[BUCKET_W-1:0];
        end else begin
            in_fast = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.load) begin
            pos_reg <= pos_inc[ROW_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_pos_reg     <= cur_pos;
            rows_reg        <= partition_rows;
            nb_reg          <= buckets[ROWS_W-1:0];
            fast_reg        <= in_fast;
            fast_bucket_reg <= in_bucket;
            fast_status_reg <= in_status;
        end
    end

    // With q = rows / buckets and r = rows mod buckets, the boundary
    // r*(q+1) = r*q + r never exceeds rows + r, so r*q fits 32 bits.
    always_comb begin
        prod_full = q_reg * r_reg;
        boundary  = {1'b0, prod_reg} + {1'b0, r_reg};
        below     = CW'(cur_pos_reg) < CW'(boundary);
        if (cmd.div2_start) begin
            if (below) begin
                div_dividend = DW'(cur_pos_reg);
                div_divisor  = {1'b0, q_reg} + DIVISOR_W'(1);
            end else begin
                div_dividend = DW'(cur_pos_reg) - DW'(r_reg);
                div_divisor  = {1'b0, q_reg};
            end
        end else begin
            div_dividend = DW'(rows_reg);
            div_divisor  = {1'b0, nb_reg};
        end
        quo_inc = {1'b0, div_quo} + (DW+1)'(1);
    end

    nba_divider #(
        .DW (DW)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div1_start | cmd.div2_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (cmd.qr_load) begin
            q_reg <= div_quo[ROWS_W-1:0];
            r_reg <= div_rem[ROWS_W-1:0];
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_full[ROWS_W-1:0];
        end
        if (cmd.res_load) begin
            if (fast_reg) begin
                bucket_reg <= fast_bucket_reg;
                status_reg <= fast_status_reg;
            end else begin
                bucket_reg <= quo_inc[BUCKET_W-1:0];
                status_reg <= ST_OK;
            end
        end
    end

    assign stat.fast     = fast_reg;
    assign stat.div_done = div_done;
    assign bucket        = bucket_reg;
    assign status        = status_reg;

endmodule

/* hdl/nba_ctrl.sv */
// ----------------------------------------------------------------------------
// nba_ctrl
// Sequencer for one row: classify; if division is needed, first division,
// multiply, boundary, bucket division; then load the output register.
// ----------------------------------------------------------------------------
module nba_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  nba_pkg::nba_stat_t stat,
    output nba_pkg::nba_cmd_t  cmd
);
    import nba_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLASS = 7'b0000010,
        S_DIV1  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_BOUND = 7'b0010000,
        S_DIV2  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                if (stat.fast) begin
                    state_next = S_OUT;
                end else begin
                    cmd.div1_start = 1'b1;
                    state_next     = S_DIV1;
                end
            end
            S_DIV1: begin
                if (stat.div_done) begin
                    cmd.qr_load = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_BOUND;
            end
            S_BOUND: begin
                cmd.div2_start = 1'b1;
                state_next     = S_DIV2;
            end
            S_DIV2: begin
                if (stat.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

/* hdl/ntile_bucket_assign_unit.sv */
// ----------------------------------------------------------------------------
// ntile_bucket_assign_unit
// NTILE window function: assigns each row of a partition its bucket number.
//
//   channel  | direction | tdata                          | tuser
//   ---------+-----------+--------------------------------+---------------------
//   s_       | in        | partition_rows, buckets        | first_row, buckets_null
//   m_       | out       | bucket                         | status
//
// A row that needs no division (null count, count below one, count above the
// row count) goes from classification straight to the output register; any
// other row first makes two passes through the shared radix-2 divider. The
// next row is accepted, at the earliest, in the cycle after the previous row is
// written to the output register. A stalled sink holds the row in the output
// stage and blocks the input. Reset clears position and valid.
// ----------------------------------------------------------------------------
module ntile_bucket_assign_unit #(
    parameter int ROW_BITS = nba_pkg::ROW_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [31:0] partition_rows, [64:32] buckets, zero pad
    input  logic [1:0]  s_tuser,   // [0] first_row, [1] buckets_null
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [32:0] bucket, zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);
    import nba_pkg::*;

    nba_cmd_t            cmd;
    nba_stat_t           stat;
    logic [BUCKET_W-1:0] bucket;
    logic [STATUS_W-1:0] status;

    nba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nba_datapath #(
        .ROW_BITS (ROW_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .first_row      (s_tuser[0]),
        .partition_rows (s_tdata[31:0]),
        .buckets        (s_tdata[64:32]),
        .buckets_null   (s_tuser[1]),
        .cmd            (cmd),
        .stat           (stat),
        .bucket         (bucket),
        .status         (status)
    );

    assign m_tdata = {7'd0, bucket};
    assign m_tuser = status;

endmodule
